FILE: design/ftmb_pkg.sv
// ----------------------------------------------------------------------------
// ftmb_pkg
// Shared types, constants and helpers for the feathered tile mosaic blender.
// ----------------------------------------------------------------------------
package ftmb_pkg;

    localparam int IMG_W_DEF = 256;
    localparam int IMG_H_DEF = 256;

    localparam logic [1:0] CMD_ACC = 2'd0;
    localparam logic [1:0] CMD_FIN = 2'd1;
    localparam logic [1:0] CMD_RD  = 2'd2;
    localparam logic [1:0] CMD_NOP = 2'd3;

    localparam logic signed [39:0] S40_MAX = 40'sh7F_FFFF_FFFF;
    localparam logic signed [39:0] S40_MIN = 40'sh80_0000_0000;
    localparam logic [19:0] W20_MAX = 20'hFFFFF;
    localparam logic [16:0] CNT17_MAX = 17'h1FFFF;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [8:0]        s_x;
        logic [8:0]        i_x;
        logic [8:0]        s_y;
        logic [8:0]        i_y;
        logic [23:0]       addr;
        logic              valid;
        logic signed [15:0] smp;
    } item_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WX,
        ST_WY,
        ST_MUL,
        ST_RD,
        ST_RMW,
        ST_WR,
        ST_FRD,
        ST_FDIV,
        ST_FWR,
        ST_PDIV,
        ST_OUT
    } state_t;

    function automatic logic signed [15:0] sat16(input logic signed [40:0] v);
        if (v > 41'sd32767)
            return 16'sh7FFF;
        else if (v < -41'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

    function automatic logic signed [39:0] sat40(input logic signed [40:0] v);
        if (v > 41'(S40_MAX))
            return S40_MAX;
        else if (v < 41'(S40_MIN))
            return S40_MIN;
        else
            return v[39:0];
    endfunction

endpackage

FILE: design/ftmb_ram.sv
// ----------------------------------------------------------------------------
// ftmb_ram
// Single port RAM with registered read.
// ----------------------------------------------------------------------------
module ftmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end

endmodule

FILE: design/ftmb_divider.sv
// ----------------------------------------------------------------------------
// ftmb_divider
// Restoring divider, one quotient bit a cycle, truncation toward zero.
// ----------------------------------------------------------------------------
module ftmb_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [40:0] dividend,
    input  logic [40:0]        divisor,
    output logic               done,
    output logic signed [40:0] quotient
);

    logic [40:0] rem_reg, rem_next;
    logic [40:0] quo_reg, quo_next;
    logic [40:0] den_reg, den_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [41:0] trial;
    logic [40:0] mag;

    always_comb
    begin
        mag       = dividend[40] ? 41'(-dividend) : dividend;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[40]} - {1'b0, den_reg};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = mag;
            den_next  = divisor;
            neg_next  = dividend[40];
            cnt_next  = 6'd41;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[41])
                rem_next = trial[40:0];
            else
                rem_next = {rem_reg[39:0], quo_reg[40]};
            quo_next = {quo_reg[39:0], ~trial[41]};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? 41'(-quo_reg) : quo_reg;

endmodule

FILE: design/ftmb_front.sv
// ----------------------------------------------------------------------------
// ftmb_front
// Command intake: decodes, range checks and queues items for the back end.
// ----------------------------------------------------------------------------
module ftmb_front #(
    parameter int IMG_W = ftmb_pkg::IMG_W_DEF,
    parameter int IMG_H = ftmb_pkg::IMG_H_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          command,
    input  logic [7:0]          tile_x0,
    input  logic [7:0]          tile_y0,
    input  logic [8:0]          tile_w,
    input  logic [8:0]          tile_h,
    input  logic [7:0]          pos_x,
    input  logic [7:0]          pos_y,
    input  logic signed [15:0]  sample,
    output logic                full,
    output logic                q_valid,
    output ftmb_pkg::item_t     q_item,
    input  logic                q_pop
);

    ftmb_pkg::item_t ent_reg [2];
    logic [1:0] cnt_reg;
    logic       rp_reg, wp_reg;
    ftmb_pkg::item_t it;
    logic [9:0] x, y;
    logic push;

    always_comb
    begin
        it      = '0;
        it.cmd  = command;
        it.smp  = sample;
        it.s_x  = tile_w;
        it.s_y  = tile_h;
        it.i_x  = {1'b0, pos_x};
        it.i_y  = {1'b0, pos_y};
        if (command == ftmb_pkg::CMD_RD)
        begin
            x = {2'b0, pos_x};
            y = {2'b0, pos_y};
            it.valid = (32'(x) < IMG_W) && (32'(y) < IMG_H);
        end
        else
        begin
            x = {2'b0, tile_x0} + {2'b0, pos_x};
            y = {2'b0, tile_y0} + {2'b0, pos_y};
            it.valid = (tile_w != 0) && (tile_h != 0) && ({1'b0, pos_x} < tile_w)
                && ({1'b0, pos_y} < tile_h) && (32'(x) < IMG_W) && (32'(y) < IMG_H);
        end
        it.addr = 24'(32'(y) * IMG_W + 32'(x));
    end

    assign full    = cnt_reg == 2'd2;
    assign push    = start && !full && (command != ftmb_pkg::CMD_NOP);
    assign q_valid = cnt_reg != 2'd0;
    assign q_item  = ent_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rp_reg  <= 1'b0;
            wp_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
            if (push)
                wp_reg <= !wp_reg;
            if (q_pop)
                rp_reg <= !rp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wp_reg] <= it;
    end

endmodule

FILE: design/ftmb_back.sv
// ----------------------------------------------------------------------------
// ftmb_back
// Executes queued items against the sum and weight stores.
// ----------------------------------------------------------------------------
module ftmb_back #(
    parameter int IMG_W = ftmb_pkg::IMG_W_DEF,
    parameter int IMG_H = ftmb_pkg::IMG_H_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [6:0]         cut_margin,
    input  logic               q_valid,
    input  ftmb_pkg::item_t    q_item,
    output logic               q_pop,
    output logic               ready,
    output logic               idle,
    output logic               done,
    output logic signed [15:0] value,
    output logic               kind,
    output logic               was_padded
);

    localparam int DEPTH = IMG_W * IMG_H;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(IMG_W);
    localparam int YW    = $clog2(IMG_H);

    ftmb_pkg::state_t st_reg, st_next;
    ftmb_pkg::item_t  it_reg, it_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [XW-1:0] fx_reg, fx_next;
    logic [YW-1:0] fy_reg, fy_next;
    logic [15:0]   wx_reg, wx_next, wy_reg, wy_next;
    logic [15:0]   w_reg, w_next;
    logic signed [39:0] tot_reg, tot_next;
    logic [16:0]   pc_reg, pc_next;
    logic signed [15:0] pad_reg, pad_next;
    logic signed [15:0] q_reg, q_next;
    logic          dn_reg, dn_next;
    logic signed [15:0] val_reg, val_next;
    logic          knd_reg, knd_next, wp_reg, wp_next;
    logic [31:0]   prod;

    logic          we;
    logic [AW-1:0] addr;
    logic [39:0]   ws_wd, ws_rd;
    logic [19:0]   wt_wd, wt_rd;

    logic               dv_start, dv_done;
    logic signed [40:0] dv_a, dv_q;
    logic [40:0]        dv_b;

    logic [9:0]  d, n;
    logic [8:0]  s_cur, i_cur;
    logic [16:0] axis_q;
    logic signed [40:0] acc;
    logic [20:0] wsum;
    logic [XW:0] xe;
    logic [YW:0] ye;
    logic        last_x, last_y, empty;
    logic signed [15:0] pix;

    ftmb_ram #(.WIDTH(40), .DEPTH(DEPTH)) u_ws (
        .clk(clk), .we(we), .addr(addr), .wdata(ws_wd), .rdata(ws_rd));
    ftmb_ram #(.WIDTH(20), .DEPTH(DEPTH)) u_wt (
        .clk(clk), .we(we), .addr(addr), .wdata(wt_wd), .rdata(wt_rd));
    ftmb_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_a),
        .divisor(dv_b), .done(dv_done), .quotient(dv_q));

    assign xe     = (XW+1)'(IMG_W) - (XW+1)'(cut_margin) - 1'b1;
    assign ye     = (YW+1)'(IMG_H) - (YW+1)'(cut_margin) - 1'b1;
    assign last_x = {1'b0, fx_reg} == xe;
    assign last_y = {1'b0, fy_reg} == ye;
    assign empty  = (32'(cut_margin) * 2 >= IMG_W) || (32'(cut_margin) * 2 >= IMG_H);
    assign prod   = wx_reg * wy_reg;

    always_comb
    begin
        st_next  = st_reg;
        it_next  = it_reg;
        clr_next = clr_reg;
        fx_next  = fx_reg;
        fy_next  = fy_reg;
        wx_next  = wx_reg;
        wy_next  = wy_reg;
        w_next   = w_reg;
        tot_next = tot_reg;
        pc_next  = pc_reg;
        pad_next = pad_reg;
        q_next   = q_reg;
        dn_next  = 1'b0;
        val_next = val_reg;
        knd_next = knd_reg;
        wp_next  = wp_reg;
        q_pop    = 1'b0;
        we       = 1'b0;
        addr     = it_reg.addr[AW-1:0];
        ws_wd    = '0;
        wt_wd    = '0;
        dv_start = 1'b0;
        dv_a     = '0;
        dv_b     = '0;
        s_cur    = (st_reg == ftmb_pkg::ST_WY) ? it_reg.s_y : it_reg.s_x;
        i_cur    = (st_reg == ftmb_pkg::ST_WY) ? it_reg.i_y : it_reg.i_x;
        d        = {1'b0, s_cur} - {i_cur, 1'b0};
        n        = {1'b0, s_cur} - (d[9] ? 10'(-d) : d);
        axis_q   = dv_q[16:0];
        acc      = $signed({ws_rd[39], ws_rd}) + 41'(it_reg.smp * $signed({1'b0, w_reg}));
        wsum     = {1'b0, wt_rd} + {5'b0, w_reg};
        pix      = ftmb_pkg::sat16(41'($signed(ws_rd) >>> 16)
                   + 41'(ws_rd[39] && (ws_rd[15:0] != 0)));
        unique case (st_reg)
            ftmb_pkg::ST_CLEAR:
            begin
                addr = clr_reg;
                we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(DEPTH - 1))
                    st_next = ftmb_pkg::ST_IDLE;
            end
            ftmb_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    it_next  = q_item;
                    knd_next = 1'b0;
                    wp_next  = 1'b0;
                    if (q_item.cmd == ftmb_pkg::CMD_FIN)
                    begin
                        tot_next = '0;
                        pc_next  = '0;
                        fx_next  = XW'(cut_margin);
                        fy_next  = YW'(cut_margin);
                        st_next  = empty ? ftmb_pkg::ST_PDIV : ftmb_pkg::ST_FRD;
                    end
                    else if (!q_item.valid)
                    begin
                        if (q_item.cmd == ftmb_pkg::CMD_RD)
                        begin
                            val_next = '0;
                            knd_next = 1'b0;
                            wp_next  = 1'b0;
                            st_next  = ftmb_pkg::ST_OUT;
                        end
                    end
                    else if (q_item.cmd == ftmb_pkg::CMD_RD)
                        st_next = ftmb_pkg::ST_RD;
                    else
                        st_next = ftmb_pkg::ST_WX;
                end
            end
            ftmb_pkg::ST_WX, ftmb_pkg::ST_WY:
            begin
                dv_a = 41'({n, 16'b0});
                dv_b = 41'(s_cur);
                if (!knd_reg)
                begin
                    dv_start = 1'b1;
                    knd_next = 1'b1;
                end
                else if (dv_done)
                begin
                    knd_next = 1'b0;
                    if (st_reg == ftmb_pkg::ST_WX)
                    begin
                        wx_next = (axis_q > 17'hFFFF) ? 16'hFFFF : axis_q[15:0];
                        st_next = ftmb_pkg::ST_WY;
                    end
                    else
                    begin
                        wy_next = (axis_q > 17'hFFFF) ? 16'hFFFF : axis_q[15:0];
                        st_next = ftmb_pkg::ST_MUL;
                    end
                end
            end
            ftmb_pkg::ST_MUL:
            begin
                w_next  = prod[31:16];
                st_next = ftmb_pkg::ST_RMW;
            end
            ftmb_pkg::ST_RMW:
            begin
                st_next = ftmb_pkg::ST_WR;
            end
            ftmb_pkg::ST_WR:
            begin
                we      = 1'b1;
                ws_wd   = ftmb_pkg::sat40(acc);
                wt_wd   = wsum[20] ? ftmb_pkg::W20_MAX : wsum[19:0];
                st_next = ftmb_pkg::ST_IDLE;
            end
            ftmb_pkg::ST_RD:
            begin
                if (it_reg.cmd == ftmb_pkg::CMD_ACC)
                    st_next = ftmb_pkg::ST_IDLE;
                else
                begin
                    st_next = ftmb_pkg::ST_OUT;
                    knd_next = 1'b0;
                    it_next.valid = 1'b1;
                    wp_next = 1'b1;
                end
            end
            ftmb_pkg::ST_FRD:
            begin
                addr = AW'(32'(fy_reg) * IMG_W + 32'(fx_reg));
                st_next = ftmb_pkg::ST_FDIV;
                dv_a = '0;
            end
            ftmb_pkg::ST_FDIV:
            begin
                addr = AW'(32'(fy_reg) * IMG_W + 32'(fx_reg));
                dv_a = $signed({ws_rd[39], ws_rd});
                dv_b = {21'b0, wt_rd};
                if (wt_rd == 0 && !knd_reg)
                    st_next = ftmb_pkg::ST_FWR;
                else if (!knd_reg)
                begin
                    dv_start = 1'b1;
                    knd_next = 1'b1;
                end
                else if (dv_done)
                begin
                    q_next   = ftmb_pkg::sat16(dv_q);
                    knd_next = 1'b0;
                    wp_next  = 1'b1;
                    st_next  = ftmb_pkg::ST_FWR;
                end
            end
            ftmb_pkg::ST_FWR:
            begin
                addr = AW'(32'(fy_reg) * IMG_W + 32'(fx_reg));
                wp_next = 1'b0;
                if (wp_reg)
                begin
                    we    = 1'b1;
                    ws_wd = {{8{q_reg[15]}}, q_reg, 16'b0};
                    wt_wd = wt_rd;
                    tot_next = ftmb_pkg::sat40(41'(tot_reg) + 41'(q_reg));
                    if (pc_reg != ftmb_pkg::CNT17_MAX)
                        pc_next = pc_reg + 1'b1;
                end
                if (last_x)
                begin
                    fx_next = XW'(cut_margin);
                    fy_next = fy_reg + 1'b1;
                end
                else
                    fx_next = fx_reg + 1'b1;
                st_next = (last_x && last_y) ? ftmb_pkg::ST_PDIV : ftmb_pkg::ST_FRD;
            end
            ftmb_pkg::ST_PDIV:
            begin
                dv_a = 41'(tot_reg);
                dv_b = {24'b0, pc_reg};
                if (pc_reg == 0)
                begin
                    pad_next = '0;
                    val_next = '0;
                    knd_next = 1'b1;
                    wp_next  = 1'b0;
                    st_next  = ftmb_pkg::ST_OUT;
                end
                else if (!knd_reg)
                begin
                    dv_start = 1'b1;
                    knd_next = 1'b1;
                end
                else if (dv_done)
                begin
                    pad_next = ftmb_pkg::sat16(dv_q);
                    val_next = ftmb_pkg::sat16(dv_q);
                    wp_next  = 1'b0;
                    st_next  = ftmb_pkg::ST_OUT;
                end
            end
            ftmb_pkg::ST_OUT:
            begin
                if (!knd_reg && wp_reg)
                begin
                    if (pix == 0)
                        val_next = pad_reg;
                    else
                    begin
                        val_next = pix;
                        wp_next  = 1'b0;
                    end
                end
                dn_next = 1'b1;
                st_next = ftmb_pkg::ST_IDLE;
            end
            default: st_next = ftmb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ftmb_pkg::ST_CLEAR;
            clr_reg <= '0;
            pad_reg <= '0;
            dn_reg  <= 1'b0;
            knd_reg <= 1'b0;
            wp_reg  <= 1'b0;
        end
        else
        begin
            st_reg  <= st_next;
            clr_reg <= clr_next;
            pad_reg <= pad_next;
            dn_reg  <= dn_next;
            knd_reg <= knd_next;
            wp_reg  <= wp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg  <= it_next;
        fx_reg  <= fx_next;
        fy_reg  <= fy_next;
        wx_reg  <= wx_next;
        wy_reg  <= wy_next;
        w_reg   <= w_next;
        tot_reg <= tot_next;
        pc_reg  <= pc_next;
        q_reg   <= q_next;
        val_reg <= val_next;
    end

    assign ready      = st_reg != ftmb_pkg::ST_CLEAR;
    assign idle       = st_reg == ftmb_pkg::ST_IDLE;
    assign done       = dn_reg;
    assign value      = val_reg;
    assign kind       = knd_reg;
    assign was_padded = wp_reg;

endmodule

FILE: design/feathered_tile_mosaic_blend.sv
// ----------------------------------------------------------------------------
// feathered_tile_mosaic_blend
// Feathered tile mosaic blender: accumulate, finalize and read commands.
// ----------------------------------------------------------------------------
// Usage: drive command and fields with start; the item transfers on a clock
// edge with start high and busy low. A two-entry queue sits between the
// command front end and the execution back end, so busy rises only when it
// is full. Finalize and read give one result, shown on value/kind/was_padded
// for exactly one cycle while done is high; the receiver cannot stall.
// Accumulate runs the two per-axis weight divides on the shared serial
// divider, then a store read-modify-write. Finalize divides each pixel
// with weight inside the margin, skips the divide for each empty pixel,
// then divides for the pad mean. After reset the back end clears both
// stores, one entry per cycle over all IMG_W*IMG_H entries, before it
// executes the first queued item.
// cut_margin_we writes cut_margin; write it only while the block is idle.
// ----------------------------------------------------------------------------
module feathered_tile_mosaic_blend #(
    parameter int IMG_W = ftmb_pkg::IMG_W_DEF,
    parameter int IMG_H = ftmb_pkg::IMG_H_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         command,
    input  logic [7:0]         tile_x0,
    input  logic [7:0]         tile_y0,
    input  logic [8:0]         tile_w,
    input  logic [8:0]         tile_h,
    input  logic [7:0]         pos_x,
    input  logic [7:0]         pos_y,
    input  logic signed [15:0] sample,
    input  logic               cut_margin_we,
    input  logic [6:0]         cut_margin_wdata,
    output logic               done,
    output logic signed [15:0] value,
    output logic               kind,
    output logic               was_padded
);

    logic [6:0] cut_reg;
    logic full, q_valid, q_pop, bk_ready, bk_idle;
    ftmb_pkg::item_t q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cut_reg <= '0;
        else if (cut_margin_we)
            cut_reg <= cut_margin_wdata;
    end

    assign busy = full;

    ftmb_front #(.IMG_W(IMG_W), .IMG_H(IMG_H)) u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .command(command),
        .tile_x0(tile_x0), .tile_y0(tile_y0), .tile_w(tile_w), .tile_h(tile_h),
        .pos_x(pos_x), .pos_y(pos_y), .sample(sample), .full(full),
        .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop));

    ftmb_back #(.IMG_W(IMG_W), .IMG_H(IMG_H)) u_back (
        .clk(clk), .rst_n(rst_n), .cut_margin(cut_reg), .q_valid(q_valid),
        .q_item(q_item), .q_pop(q_pop), .ready(bk_ready), .idle(bk_idle),
        .done(done), .value(value), .kind(kind), .was_padded(was_padded));

    a_pop_ready: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (bk_ready && bk_idle && q_valid))
        else $error("queue popped while back end not ready");

    a_fin_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (done && kind) |-> !was_padded)
        else $error("finalize result flagged as padded");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

endmodule
